// ===== rtl/voice_allocator_with_stealing_defines.svh =====
// Assertion macros shared by the voice allocator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef VOICE_ALLOCATOR_WITH_STEALING_DEFINES_SVH
`define VOICE_ALLOCATOR_WITH_STEALING_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VAS_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("voice allocator implication violated");

// Next-cycle implication, checked outside reset.
`define VAS_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("voice allocator sequence violated");

`endif

// ===== rtl/vas_pkg.sv =====
// Shared widths, codes and structs for the voice allocator.
// No dependencies; used by vas_cell and voice_allocator_with_stealing.
package vas_pkg;

    // Voice index width covers the full range of the voice table size.
    localparam int VIDX_W = 6;
    localparam int CNT_W  = 5;
    localparam int PRI_W  = 8;
    localparam int MODE_W = 8;
    localparam int LVL_W  = 16;
    localparam int AGE_W  = 16;

    localparam logic [MODE_W-1:0] MODE_IDLE  = 8'd0;
    localparam logic [MODE_W-1:0] MODE_NOISE = 8'd2;

    localparam logic CMD_ALLOC  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Running search result handed from cell to cell.
    typedef struct packed {
        logic              vld;
        logic              free_have;
        logic [VIDX_W-1:0] free_pick;
        logic              have;
        logic [VIDX_W-1:0] pick;
        logic [PRI_W-1:0]  bp;
        logic [LVL_W-1:0]  bl;
        logic [AGE_W-1:0]  ba;
        logic              noise;
    } vas_cand_t;

    // Broadcast write-back applied to all cells in the same cycle.
    typedef struct packed {
        logic              alloc_en;
        logic [VIDX_W-1:0] pick;
        logic [PRI_W-1:0]  req;
        logic              upd_en;
        logic [VIDX_W-1:0] upd_idx;
        logic [MODE_W-1:0] mode;
        logic [LVL_W-1:0]  level;
    } vas_commit_t;

endpackage

// ===== rtl/vas_cell.sv =====
// One voice cell: holds a voice's mode, level, age and priority, and
// refines the search candidate passing through it. Depends on vas_pkg.
module vas_cell #(
    parameter int IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [vas_pkg::PRI_W-1:0]   req_priority,
    input  logic [vas_pkg::CNT_W-1:0]   voice_count,
    input  vas_pkg::vas_cand_t          cand_in,
    output vas_pkg::vas_cand_t          cand_out,
    input  vas_pkg::vas_commit_t        commit
);
    import vas_pkg::*;

    localparam logic [VIDX_W-1:0] MY_IDX = VIDX_W'(IDX);

    logic [MODE_W-1:0] mode_reg,  mode_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [AGE_W-1:0]  age_reg,   age_next;
    logic [PRI_W-1:0]  pri_reg,   pri_next;
    vas_cand_t         cand_reg,  cand_next;

    logic active;
    logic is_free;
    logic better;

    assign active  = (IDX < int'(voice_count));
    assign is_free = (mode_reg == MODE_IDLE) && (level_reg == '0);

    // Steal order (pri <= req): lowest priority, lowest level, oldest.
    always_comb
    begin
        better = 1'b0;
        if (pri_reg <= req_priority)
        begin
            if (!cand_in.have)
                better = 1'b1;
            else if (pri_reg != cand_in.bp)
                better = (pri_reg < cand_in.bp);
            else if (level_reg != cand_in.bl)
                better = (level_reg < cand_in.bl);
            else
                better = (age_reg > cand_in.ba);
        end
    end

    // Fold this voice into the candidate on its way down the chain.
    always_comb
    begin
        cand_next = cand_in;
        if (cand_in.vld && active)
        begin
            if (!cand_in.free_have && is_free)
            begin
                cand_next.free_have = 1'b1;
                cand_next.free_pick = MY_IDX;
            end
            if (better)
            begin
                cand_next.have  = 1'b1;
                cand_next.pick  = MY_IDX;
                cand_next.bp    = pri_reg;
                cand_next.bl    = level_reg;
                cand_next.ba    = age_reg;
                cand_next.noise = (mode_reg == MODE_NOISE);
            end
        end
    end

    // Write-back of a grant or a status update.
    always_comb
    begin
        mode_next  = mode_reg;
        level_next = level_reg;
        age_next   = age_reg;
        pri_next   = pri_reg;
        if (commit.alloc_en)
        begin
            if (commit.pick == MY_IDX)
            begin
                age_next = '0;
                pri_next = commit.req;
            end
            else if (active)
            begin
                age_next = age_reg + AGE_W'(1);
            end
        end
        if (commit.upd_en && (commit.upd_idx == MY_IDX))
        begin
            mode_next  = commit.mode;
            level_next = commit.level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= '0;
            level_reg <= '0;
            age_reg   <= '0;
            pri_reg   <= '0;
            cand_reg  <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            level_reg <= level_next;
            age_reg   <= age_next;
            pri_reg   <= pri_next;
            cand_reg  <= cand_next;
        end
    end

    assign cand_out = cand_reg;

endmodule

// ===== rtl/voice_allocator_with_stealing.sv =====
// Voice allocator with stealing: a row of MAX_VOICES voice cells that a search
// candidate walks one cell per cycle; depends on vas_pkg and the defines header.
// Allocate: the candidate walks the cell chain and its result is registered in fin_reg;
// Update: the command alone is registered. Both then write back and publish through the
// output register when the slot frees; s_tready is low until the result is published.
// Reset clears every voice's mode, level, age and priority and sets voice_count to 24.
`include "voice_allocator_with_stealing_defines.svh"

module voice_allocator_with_stealing #(
    parameter int MAX_VOICES = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] request_priority, [12:8] voice_index, [20:13] voice_mode,
    // [36:21] voice_level, [39:37] zero
    input  logic [39:0] s_tdata,
    // [0] command
    input  logic [0:0]  s_tuser,
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] granted, [5:1] chosen_voice, [6] noise_release, [7] zero
    output logic [7:0]  m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vas_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic ADDR_VOICE_COUNT = 1'b0;
    localparam logic [CNT_W-1:0] COUNT_RESET = 5'd24;

    logic [1:0]        state_reg, state_next;
    logic              cmd_reg, cmd_next;
    logic [PRI_W-1:0]  req_reg, req_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [MODE_W-1:0] umode_reg, umode_next;
    logic [LVL_W-1:0]  ulevel_reg, ulevel_next;
    logic              start_reg, start_next;
    vas_cand_t         fin_reg, fin_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_tdata_reg, m_tdata_next;

    vas_cand_t   chain [0:MAX_VOICES];
    vas_cand_t   head_cand;
    vas_commit_t commit;

    logic             slot_free;
    logic             commit_fire;
    logic             res_granted;
    logic [CNT_W-1:0] res_chosen;
    logic             res_noise;

    // Configuration register (voice_count).
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_VOICE_COUNT) ? {27'd0, count_reg} : 32'd0;

    always_comb
    begin
        count_next = count_reg;
        if (psel && penable && pwrite && (paddr[2] == ADDR_VOICE_COUNT))
            count_next = pwdata[CNT_W-1:0];
    end

    // The cell chain; the head cell sees a fresh candidate on start.
    always_comb
    begin
        head_cand     = '0;
        head_cand.vld = start_reg;
    end

    assign chain[0] = head_cand;

    genvar g;
    generate
        for (g = 0; g < MAX_VOICES; g++)
        begin : g_cell
            vas_cell #(
                .IDX(g)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .req_priority (req_reg),
                .voice_count  (count_reg),
                .cand_in      (chain[g]),
                .cand_out     (chain[g+1]),
                .commit       (commit)
            );
        end
    endgenerate

    assign slot_free   = !m_tvalid_reg || m_tready;
    assign commit_fire = (state_reg == ST_DONE) && slot_free;

    // Allocate result: free voice first, then stolen voice; an update reports all zeros.
    always_comb
    begin
        res_granted = 1'b0;
        res_chosen  = '0;
        res_noise   = 1'b0;
        if (cmd_reg == CMD_ALLOC)
        begin
            if (fin_reg.free_have)
            begin
                res_granted = 1'b1;
                res_chosen  = fin_reg.free_pick[CNT_W-1:0];
            end
            else if (fin_reg.have)
            begin
                res_granted = 1'b1;
                res_chosen  = fin_reg.pick[CNT_W-1:0];
                res_noise   = fin_reg.noise;
            end
            else
            begin
                res_chosen  = count_reg;
            end
        end
    end

    // Write-back broadcast to all cells.
    always_comb
    begin
        commit          = '0;
        commit.alloc_en = commit_fire && (cmd_reg == CMD_ALLOC) && res_granted;
        commit.pick     = fin_reg.free_have ? fin_reg.free_pick : fin_reg.pick;
        commit.req      = req_reg;
        commit.upd_en   = commit_fire && (cmd_reg == CMD_UPDATE);
        commit.upd_idx  = VIDX_W'(idx_reg);
        commit.mode     = umode_reg;
        commit.level    = ulevel_reg;
    end

    // Sequencer: accept, scan the chain (allocate only), then write back and publish.
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        req_next    = req_reg;
        idx_next    = idx_reg;
        umode_next  = umode_reg;
        ulevel_next = ulevel_reg;
        start_next  = 1'b0;
        fin_next    = fin_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next    = s_tuser[0];
                    req_next    = s_tdata[7:0];
                    idx_next    = s_tdata[12:8];
                    umode_next  = s_tdata[20:13];
                    ulevel_next = s_tdata[36:21];
                    if (s_tuser[0] == CMD_UPDATE)
                        state_next = ST_DONE;
                    else
                    begin
                        state_next = ST_SCAN;
                        start_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (chain[MAX_VOICES].vld)
                begin
                    fin_next   = chain[MAX_VOICES];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register parts the result from the next transaction.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (commit_fire)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, res_noise, res_chosen, res_granted};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            start_reg    <= 1'b0;
            count_reg    <= COUNT_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            start_reg    <= start_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        req_reg     <= req_next;
        idx_reg     <= idx_next;
        umode_reg   <= umode_next;
        ulevel_reg  <= ulevel_next;
        fin_reg     <= fin_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks on the sequencer and the chain.
    `VAS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, s_tvalid && s_tready, state_reg != ST_IDLE)
    `VAS_ASSERT_IMPLY(a_chain_end_in_scan, clk, rst_n, chain[MAX_VOICES].vld, state_reg == ST_SCAN)
    `VAS_ASSERT_IMPLY(a_grant_has_winner, clk, rst_n, commit.alloc_en, fin_reg.free_have || fin_reg.have)
    `VAS_ASSERT_NEXT(a_commit_publishes, clk, rst_n, commit_fire, m_tvalid_reg && (state_reg == ST_IDLE))

endmodule
